### rtl/sic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and constants for the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int QUOT_BITS = 26;   // quotient magnitude bits, cap at 2^26
  localparam int OUT_BITS  = 24;
  localparam int TOL_BITS  = 16;
  localparam int KIND_BITS = 4;
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_AREA_TOL  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_PARAM_TOL = 2'd1;

  localparam logic [KIND_BITS-1:0] KIND_NONE      = 4'd0;
  localparam logic [KIND_BITS-1:0] KIND_X         = 4'd1;
  localparam logic [KIND_BITS-1:0] KIND_T_Q       = 4'd2;
  localparam logic [KIND_BITS-1:0] KIND_T_P       = 4'd3;
  localparam logic [KIND_BITS-1:0] KIND_V         = 4'd4;
  localparam logic [KIND_BITS-1:0] KIND_X_OVL     = 4'd5;
  localparam logic [KIND_BITS-1:0] KIND_T_OVL_Q   = 4'd6;
  localparam logic [KIND_BITS-1:0] KIND_T_OVL_P   = 4'd7;
  localparam logic [KIND_BITS-1:0] KIND_V_OVL     = 4'd8;

  typedef enum logic [1:0] {
    PATH_NONE,
    PATH_CROSS,
    PATH_COLLINEAR
  } sic_path_t;

  typedef struct packed {
    logic      valid;
    sic_path_t path;
  } sic_ctrl_t;

endpackage

### rtl/sic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_front
// Differences, products, areas and dot products; picks the case and sets up
// both divisions (magnitude, sign, overflow, first partial remainder).
// ----------------------------------------------------------------------------
module sic_front #(
  parameter int C  = 16,
  parameter int F  = 16,
  parameter int AW = 2 * C + 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req,
  input  logic signed [C-1:0]                  p1x,
  input  logic signed [C-1:0]                  p1y,
  input  logic signed [C-1:0]                  p2x,
  input  logic signed [C-1:0]                  p2y,
  input  logic signed [C-1:0]                  q1x,
  input  logic signed [C-1:0]                  q1y,
  input  logic signed [C-1:0]                  q2x,
  input  logic signed [C-1:0]                  q2y,
  input  logic [sic_pkg::TOL_BITS-1:0]         area_tol,
  output sic_pkg::sic_ctrl_t                   ctrl,
  output logic [AW-1:0]                        a_r,
  output logic [AW-1:0]                        a_d,
  output logic [sic_pkg::QUOT_BITS-1:0]        a_lo,
  output logic                                 a_neg,
  output logic                                 a_ovf,
  output logic [AW-1:0]                        b_r,
  output logic [AW-1:0]                        b_d,
  output logic [sic_pkg::QUOT_BITS-1:0]        b_lo,
  output logic                                 b_neg,
  output logic                                 b_ovf
);

  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int QB = sic_pkg::QUOT_BITS;
  localparam int SH = QB - F;

  // stage A: differences
  logic signed [DW-1:0] u1x, u1y, u2x, u2y, v1x, v1y, v2x, v2y, dpx, dpy, dqx, dqy;
  logic                 va, zla;

  // stage B: products
  logic signed [PW-1:0] m0, m1, m2, m3, m4, m5, m6, m7;
  logic signed [PW-1:0] m8, m9, m10, m11, m12, m13, m14, m15;
  logic                 vb, zlb;

  // stage C: areas and dots
  logic signed [AW-1:0] ap1, ap2, aq1, aq2, dotp, dotq, lp, lq;
  logic                 vc, zlc;

  // stage D: selected fractions
  logic signed [AW-1:0] na, da, nb, db;
  sic_pkg::sic_ctrl_t   ctrl_d;

  logic signed [AW-1:0] diff_ap, diff_aq;
  logic [AW-1:0]        abs_diff, abs_ap1, tol_w;
  logic                 nonpar, colin;
  sic_pkg::sic_path_t   path_next;
  logic signed [AW-1:0] na_next, da_next, nb_next, db_next;

  logic [AW-1:0]        a_n, a_dm, b_n, b_dm;
  logic [AW+F-1:0]      a_sh, b_sh;

  always_ff @(posedge clk) begin
    u1x <= DW'(q1x) - DW'(p1x);
    u1y <= DW'(q1y) - DW'(p1y);
    u2x <= DW'(q2x) - DW'(p1x);
    u2y <= DW'(q2y) - DW'(p1y);
    v1x <= DW'(q1x) - DW'(p2x);
    v1y <= DW'(q1y) - DW'(p2y);
    v2x <= DW'(q2x) - DW'(p2x);
    v2y <= DW'(q2y) - DW'(p2y);
    dpx <= DW'(p2x) - DW'(p1x);
    dpy <= DW'(p2y) - DW'(p1y);
    dqx <= DW'(q2x) - DW'(q1x);
    dqy <= DW'(q2y) - DW'(q1y);
    zla <= (p1x == p2x && p1y == p2y) || (q1x == q2x && q1y == q2y);

    m0  <= u1x * u2y;  m1  <= u1y * u2x;
    m2  <= v1x * v2y;  m3  <= v1y * v2x;
    m4  <= u1x * v1y;  m5  <= u1y * v1x;
    m6  <= u2x * v2y;  m7  <= u2y * v2x;
    m8  <= u1x * dpx;  m9  <= u1y * dpy;
    m10 <= u1x * dqx;  m11 <= u1y * dqy;
    m12 <= dpx * dpx;  m13 <= dpy * dpy;
    m14 <= dqx * dqx;  m15 <= dqy * dqy;
    zlb <= zla;

    ap1  <= AW'(m0)  - AW'(m1);
    ap2  <= AW'(m2)  - AW'(m3);
    aq1  <= AW'(m4)  - AW'(m5);
    aq2  <= AW'(m6)  - AW'(m7);
    dotp <= AW'(m8)  + AW'(m9);
    dotq <= AW'(m10) + AW'(m11);
    lp   <= AW'(m12) + AW'(m13);
    lq   <= AW'(m14) + AW'(m15);
    zlc  <= zlb;

    na <= na_next;
    da <= da_next;
    nb <= nb_next;
    db <= db_next;

    a_neg <= (na != '0) && ((na < 0) != (da < 0));
    b_neg <= (nb != '0) && ((nb < 0) != (db < 0));
    a_ovf <= (a_n >> SH) >= a_dm;
    b_ovf <= (b_n >> SH) >= b_dm;
    a_r   <= ((a_n >> SH) >= a_dm) ? '0 : (a_n >> SH);
    b_r   <= ((b_n >> SH) >= b_dm) ? '0 : (b_n >> SH);
    a_d   <= a_dm;
    b_d   <= b_dm;
    a_lo  <= a_sh[QB-1:0];
    b_lo  <= b_sh[QB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= 1'b0;
      vb     <= 1'b0;
      vc     <= 1'b0;
      ctrl_d <= '0;
      ctrl   <= '0;
    end else begin
      va          <= req;
      vb          <= va;
      vc          <= vb;
      ctrl_d.valid <= vc;
      ctrl_d.path  <= path_next;
      ctrl        <= ctrl_d;
    end
  end

  always_comb begin
    diff_ap  = ap1 - ap2;
    diff_aq  = aq1 - aq2;
    abs_diff = (diff_ap < 0) ? AW'(-diff_ap) : AW'(diff_ap);
    abs_ap1  = (ap1 < 0) ? AW'(-ap1) : AW'(ap1);
    tol_w    = AW'(area_tol);
    nonpar   = abs_diff > tol_w;
    colin    = abs_ap1 <= tol_w;
    path_next = sic_pkg::PATH_NONE;
    na_next  = dotp;
    da_next  = lp;
    nb_next  = -dotq;
    db_next  = lq;
    if (zlc) begin
      path_next = sic_pkg::PATH_NONE;
    end else if (nonpar) begin
      na_next = ap1;
      da_next = diff_ap;
      nb_next = aq1;
      db_next = diff_aq;
      path_next = (diff_aq == '0) ? sic_pkg::PATH_NONE : sic_pkg::PATH_CROSS;
    end else if (colin) begin
      path_next = sic_pkg::PATH_COLLINEAR;
    end
    if (path_next == sic_pkg::PATH_NONE) begin
      da_next = AW'(1);
      db_next = AW'(1);
    end
  end

  always_comb begin
    a_n  = (na < 0) ? AW'(-na) : AW'(na);
    a_dm = (da < 0) ? AW'(-da) : AW'(da);
    b_n  = (nb < 0) ? AW'(-nb) : AW'(nb);
    b_dm = (db < 0) ? AW'(-db) : AW'(db);
    a_sh = (AW+F)'(a_n) << F;
    b_sh = (AW+F)'(b_n) << F;
  end

endmodule

### rtl/sic_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_div_cell
// One restoring-division step: one quotient bit per cell, handed onward.
// ----------------------------------------------------------------------------
module sic_div_cell #(
  parameter int AW = 37,
  parameter int QB = 26
) (
  input  logic          clk,
  input  logic [AW-1:0] r_in,
  input  logic [AW-1:0] d_in,
  input  logic [QB-1:0] lo_in,
  input  logic [QB-1:0] q_in,
  input  logic          neg_in,
  input  logic          ovf_in,
  output logic [AW-1:0] r_out,
  output logic [AW-1:0] d_out,
  output logic [QB-1:0] lo_out,
  output logic [QB-1:0] q_out,
  output logic          neg_out,
  output logic          ovf_out
);

  logic [AW:0] t, sub;
  logic        ge;

  always_comb begin
    t   = {r_in, lo_in[QB-1]};
    sub = t - {1'b0, d_in};
    ge  = t >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    r_out   <= ge ? sub[AW-1:0] : t[AW-1:0];
    d_out   <= d_in;
    lo_out  <= lo_in << 1;
    q_out   <= {q_in[QB-2:0], ge};
    neg_out <= neg_in;
    ovf_out <= ovf_in;
  end

endmodule

### rtl/sic_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_classify
// Tolerance tests on both quotients, kind decode and saturated fields.
// ----------------------------------------------------------------------------
module sic_classify #(
  parameter int F  = 16,
  parameter int AW = 37
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sic_pkg::sic_ctrl_t                    ctrl,
  input  logic [sic_pkg::TOL_BITS-1:0]          param_tol,
  input  logic [AW-1:0]                         a_r,
  input  logic [sic_pkg::QUOT_BITS-1:0]         a_q,
  input  logic                                  a_neg,
  input  logic                                  a_ovf,
  input  logic [AW-1:0]                         b_r,
  input  logic [sic_pkg::QUOT_BITS-1:0]         b_q,
  input  logic                                  b_neg,
  input  logic                                  b_ovf,
  output logic                                  done,
  output logic [sic_pkg::KIND_BITS-1:0]         kind,
  output logic signed [sic_pkg::OUT_BITS-1:0]   alpha,
  output logic signed [sic_pkg::OUT_BITS-1:0]   beta
);

  localparam int QB = sic_pkg::QUOT_BITS;
  localparam int MW = QB + 1;
  localparam int OW = sic_pkg::OUT_BITS;
  localparam logic [MW-1:0] ONE = MW'(1) << F;
  localparam logic [MW-1:0] LIM = MW'(1) << (OW - 1);

  logic [MW-1:0] a_mag, b_mag, tol;
  logic          a_st, b_st, ai, az, ao, bi, bz, bo;
  logic [sic_pkg::KIND_BITS-1:0] kind_next;
  logic [OW-1:0] a_fld, b_fld;

  always_comb begin
    tol   = MW'(param_tol);
    a_mag = a_ovf ? (MW'(1) << QB) : MW'(a_q);
    b_mag = b_ovf ? (MW'(1) << QB) : MW'(b_q);
    a_st  = a_ovf || (a_r != '0);
    b_st  = b_ovf || (b_r != '0);
    ai = !a_neg && (a_mag > tol || (a_mag == tol && a_st)) && tol < ONE
         && a_mag < ONE - tol;
    bi = !b_neg && (b_mag > tol || (b_mag == tol && b_st)) && tol < ONE
         && b_mag < ONE - tol;
    az = !ai && (a_mag < tol || (a_mag == tol && !a_st));
    bz = !bi && (b_mag < tol || (b_mag == tol && !b_st));
    ao = !ai && !az;
    bo = !bi && !bz;
    kind_next = sic_pkg::KIND_NONE;
    unique case (ctrl.path)
      sic_pkg::PATH_CROSS: begin
        if (ai && bi)      kind_next = sic_pkg::KIND_X;
        else if (az && bi) kind_next = sic_pkg::KIND_T_Q;
        else if (bz && ai) kind_next = sic_pkg::KIND_T_P;
        else if (az && bz) kind_next = sic_pkg::KIND_V;
      end
      sic_pkg::PATH_COLLINEAR: begin
        if (ai && bi)      kind_next = sic_pkg::KIND_X_OVL;
        else if (ao && bi) kind_next = sic_pkg::KIND_T_OVL_Q;
        else if (bo && ai) kind_next = sic_pkg::KIND_T_OVL_P;
        else if (az && bz) kind_next = sic_pkg::KIND_V_OVL;
      end
      default: kind_next = sic_pkg::KIND_NONE;
    endcase
    if (a_neg) a_fld = (a_mag >= LIM) ? OW'(LIM) : OW'(-a_mag);
    else       a_fld = (a_mag >= LIM) ? OW'(LIM - MW'(1)) : OW'(a_mag);
    if (b_neg) b_fld = (b_mag >= LIM) ? OW'(LIM) : OW'(-b_mag);
    else       b_fld = (b_mag >= LIM) ? OW'(LIM - MW'(1)) : OW'(b_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
    kind  <= kind_next;
    alpha <= (kind_next == sic_pkg::KIND_NONE) ? '0 : a_fld;
    beta  <= (kind_next == sic_pkg::KIND_NONE) ? '0 : b_fld;
  end

endmodule

### rtl/segment_intersection_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_classifier_top
// Classifies the intersection of two segments and gives alpha and beta.
// ----------------------------------------------------------------------------
// Pipeline: done rises after the request passes 5 front stages, one divider
//   cell per quotient bit (26 cells) and one output register.
// Throughput: one request per cycle; busy is always low, done is a strobe.
// Reset: clears the tolerances and all valid flags in the pipeline.
module segment_intersection_classifier_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          p_start_x,
  input  logic signed [COORD_BITS-1:0]          p_start_y,
  input  logic signed [COORD_BITS-1:0]          p_end_x,
  input  logic signed [COORD_BITS-1:0]          p_end_y,
  input  logic signed [COORD_BITS-1:0]          q_start_x,
  input  logic signed [COORD_BITS-1:0]          q_start_y,
  input  logic signed [COORD_BITS-1:0]          q_end_x,
  input  logic signed [COORD_BITS-1:0]          q_end_y,
  input  logic                                  cfg_we,
  input  logic [sic_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [sic_pkg::TOL_BITS-1:0]          cfg_data,
  output logic                                  done,
  output logic [sic_pkg::KIND_BITS-1:0]         kind,
  output logic signed [sic_pkg::OUT_BITS-1:0]   alpha,
  output logic signed [sic_pkg::OUT_BITS-1:0]   beta
);

  localparam int AW = 2 * COORD_BITS + 5;
  localparam int QB = sic_pkg::QUOT_BITS;

  logic [sic_pkg::TOL_BITS-1:0] area_tol, param_tol;

  sic_pkg::sic_ctrl_t ctrl_pipe [0:QB];
  logic [AW-1:0] a_r [0:QB], a_d [0:QB], b_r [0:QB], b_d [0:QB];
  logic [QB-1:0] a_lo [0:QB], a_q [0:QB], b_lo [0:QB], b_q [0:QB];
  logic          a_neg [0:QB], a_ovf [0:QB], b_neg [0:QB], b_ovf [0:QB];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_tol  <= '0;
      param_tol <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sic_pkg::REG_AREA_TOL:  area_tol  <= cfg_data;
        sic_pkg::REG_PARAM_TOL: param_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  sic_front #(.C(COORD_BITS), .F(FRAC_BITS), .AW(AW)) u_front (
    .clk(clk), .rst(rst), .req(start && !busy),
    .p1x(p_start_x), .p1y(p_start_y), .p2x(p_end_x), .p2y(p_end_y),
    .q1x(q_start_x), .q1y(q_start_y), .q2x(q_end_x), .q2y(q_end_y),
    .area_tol(area_tol), .ctrl(ctrl_pipe[0]),
    .a_r(a_r[0]), .a_d(a_d[0]), .a_lo(a_lo[0]), .a_neg(a_neg[0]), .a_ovf(a_ovf[0]),
    .b_r(b_r[0]), .b_d(b_d[0]), .b_lo(b_lo[0]), .b_neg(b_neg[0]), .b_ovf(b_ovf[0])
  );

  assign a_q[0] = '0;
  assign b_q[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    sic_div_cell #(.AW(AW), .QB(QB)) u_a (
      .clk(clk),
      .r_in(a_r[i]), .d_in(a_d[i]), .lo_in(a_lo[i]), .q_in(a_q[i]),
      .neg_in(a_neg[i]), .ovf_in(a_ovf[i]),
      .r_out(a_r[i+1]), .d_out(a_d[i+1]), .lo_out(a_lo[i+1]), .q_out(a_q[i+1]),
      .neg_out(a_neg[i+1]), .ovf_out(a_ovf[i+1])
    );
    sic_div_cell #(.AW(AW), .QB(QB)) u_b (
      .clk(clk),
      .r_in(b_r[i]), .d_in(b_d[i]), .lo_in(b_lo[i]), .q_in(b_q[i]),
      .neg_in(b_neg[i]), .ovf_in(b_ovf[i]),
      .r_out(b_r[i+1]), .d_out(b_d[i+1]), .lo_out(b_lo[i+1]), .q_out(b_q[i+1]),
      .neg_out(b_neg[i+1]), .ovf_out(b_ovf[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_pipe[i+1] <= '0;
      end else begin
        ctrl_pipe[i+1] <= ctrl_pipe[i];
      end
    end
  end

  sic_classify #(.F(FRAC_BITS), .AW(AW)) u_classify (
    .clk(clk), .rst(rst), .ctrl(ctrl_pipe[QB]), .param_tol(param_tol),
    .a_r(a_r[QB]), .a_q(a_q[QB]), .a_neg(a_neg[QB]), .a_ovf(a_ovf[QB]),
    .b_r(b_r[QB]), .b_q(b_q[QB]), .b_neg(b_neg[QB]), .b_ovf(b_ovf[QB]),
    .done(done), .kind(kind), .alpha(alpha), .beta(beta)
  );

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && kind == sic_pkg::KIND_NONE |-> alpha == '0 && beta == '0)
    else $error("kind none with nonzero parameters");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    done |-> kind <= sic_pkg::KIND_V_OVL)
    else $error("kind code out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_no_stall: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule
